[rtl/stt_pkg.sv]
// shared types and constants for the search transposition table
package stt_pkg;

    localparam int KEY_W      = 64;
    localparam int DEPTH_W    = 8;
    localparam int SCORE_W    = 31;
    localparam int BOUND_W    = 2;
    localparam int SQ_W       = 9;

    // stream beat widths, whole bytes
    localparam int S_FIELDS_W = KEY_W + DEPTH_W + 3 * SCORE_W + BOUND_W + 2 * SQ_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + SCORE_W + 1 + 2 * SQ_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // request kinds carried on s_tuser
    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // bound kinds
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        logic        [SQ_W-1:0]    to_sq;
        logic        [SQ_W-1:0]    from_sq;
        logic        [BOUND_W-1:0] bound;
        logic signed [SCORE_W-1:0] score;
        logic        [DEPTH_W-1:0] depth;
        logic        [KEY_W-1:0]   key;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write zero at the sweep address and advance
        logic load;    // capture request and read its slot
        logic commit;  // update slot on store, load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

[rtl/stt_ctrl.sv]
// controller state machine: reset sweep, request accept, result hand-off
module stt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output stt_pkg::cmd_t cmd,
    input  stt_pkg::sts_t sts
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;

    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.commit = (state_reg == ST_DECIDE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !cmd.load && !cmd.commit)
        else $error("request taken during table sweep");

    a_load_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !s_tready && !cmd.load)
        else $error("second request taken before the first was decided");

    a_commit_shows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("decided request produced no result beat");

    a_sweep_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear && sts.clear_last |=> s_tready && !m_tvalid)
        else $error("sweep did not end in idle");

endmodule

[rtl/stt_datapath.sv]
// datapath: slot memory, request registers, hit and replace logic, result register
module stt_datapath
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stt_pkg::cmd_t                  cmd,
    output stt_pkg::sts_t                  sts,
    input  logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic [stt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import stt_pkg::*;

    localparam int SLOTS = 1 << INDEX_BITS;
    localparam int M_PAD = M_TDATA_W - M_FIELDS_W;

    // input beat fields
    localparam int KEY_LO   = 0;
    localparam int DEPTH_LO = KEY_LO + KEY_W;
    localparam int ALPHA_LO = DEPTH_LO + DEPTH_W;
    localparam int BETA_LO  = ALPHA_LO + SCORE_W;
    localparam int VALUE_LO = BETA_LO + SCORE_W;
    localparam int BOUND_LO = VALUE_LO + SCORE_W;
    localparam int FROM_LO  = BOUND_LO + BOUND_W;
    localparam int TO_LO    = FROM_LO + SQ_W;

    slot_t                     mem [SLOTS];
    slot_t                     rd_reg;
    slot_t                     wr_data;
    logic [INDEX_BITS-1:0]     wr_addr;
    logic                      wr_en;

    logic [INDEX_BITS-1:0]     clr_addr_reg;
    logic [INDEX_BITS-1:0]     clr_addr_next;

    logic                      func_reg;
    logic        [KEY_W-1:0]   key_reg;
    logic        [DEPTH_W-1:0] depth_reg;
    logic signed [SCORE_W-1:0] alpha_reg;
    logic signed [SCORE_W-1:0] beta_reg;
    logic signed [SCORE_W-1:0] value_reg;
    logic        [BOUND_W-1:0] bound_reg;
    logic        [SQ_W-1:0]    from_reg;
    logic        [SQ_W-1:0]    to_reg;

    logic                      hit;
    logic                      deep;
    logic                      replace;
    logic                      cutoff_c;
    logic                      hint_c;

    logic                      out_cutoff_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic                      out_hint_reg;
    logic        [SQ_W-1:0]    out_from_reg;
    logic        [SQ_W-1:0]    out_to_reg;
    logic                      out_written_reg;

    // reset sweep address
    assign clr_addr_next  = clr_addr_reg + 1'b1;
    assign sts.clear_last = (clr_addr_reg == {INDEX_BITS{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_next;
    end

    // request registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= s_tuser;
            key_reg   <= s_tdata[KEY_LO +: KEY_W];
            depth_reg <= s_tdata[DEPTH_LO +: DEPTH_W];
            alpha_reg <= s_tdata[ALPHA_LO +: SCORE_W];
            beta_reg  <= s_tdata[BETA_LO +: SCORE_W];
            value_reg <= s_tdata[VALUE_LO +: SCORE_W];
            bound_reg <= s_tdata[BOUND_LO +: BOUND_W];
            from_reg  <= s_tdata[FROM_LO +: SQ_W];
            to_reg    <= s_tdata[TO_LO +: SQ_W];
        end
    end

    // empty slot or not deeper than the new entry
    assign replace = (rd_reg.key == '0) || (rd_reg.depth <= depth_reg);
    assign hit     = (key_reg != '0) && (rd_reg.key == key_reg);
    assign deep    = (rd_reg.depth >= depth_reg);

    assign wr_en   = cmd.clear || (cmd.commit && (func_reg == FUNC_STORE) && replace);
    assign wr_addr = cmd.clear ? clr_addr_reg : key_reg[INDEX_BITS-1:0];

    always_comb
    begin
        wr_data = '0;
        if (!cmd.clear)
        begin
            wr_data.key     = key_reg;
            wr_data.depth   = depth_reg;
            wr_data.score   = value_reg;
            wr_data.bound   = bound_reg;
            wr_data.from_sq = from_reg;
            wr_data.to_sq   = to_reg;
        end
    end

    // slot index is read straight from the accepted beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.load)
            rd_reg <= mem[s_tdata[KEY_LO +: INDEX_BITS]];
    end

    always_comb
    begin
        cutoff_c = 1'b0;
        hint_c   = 1'b0;
        if ((func_reg == FUNC_PROBE) && hit)
        begin
            if (deep)
            begin
                case (rd_reg.bound)
                    BOUND_EXACT:
                    begin
                        cutoff_c = 1'b1;
                        hint_c   = 1'b1;
                    end
                    BOUND_LOWER:
                    begin
                        cutoff_c = (rd_reg.score >= beta_reg);
                    end
                    BOUND_UPPER:
                    begin
                        cutoff_c = (rd_reg.score <= alpha_reg);
                    end
                    default:
                    begin
                        cutoff_c = 1'b0;
                    end
                endcase
            end
            else
            begin
                // too shallow for a score, still a useful move
                hint_c = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_cutoff_reg  <= cutoff_c;
            out_score_reg   <= cutoff_c ? rd_reg.score : '0;
            out_hint_reg    <= hint_c;
            out_from_reg    <= hint_c ? rd_reg.from_sq : '1;
            out_to_reg      <= hint_c ? rd_reg.to_sq : '1;
            out_written_reg <= (func_reg == FUNC_STORE) && replace;
        end
    end

    assign m_tdata = {{M_PAD{1'b0}}, out_written_reg, out_to_reg, out_from_reg,
                      out_hint_reg, out_score_reg, out_cutoff_reg};

endmodule

[rtl/search_transposition_table.sv]
// top level of the search transposition table
//
// Direct-mapped table of 2**INDEX_BITS slots addressed by the low key bits.
// Slave channel: one beat is one request; s_tuser selects probe (0) or
// store (1), s_tdata carries key, depth, window, score, bound and move.
// Master channel: one result beat per request, carrying cutoff, score,
// move hint and the store's written flag.
// After reset the block sweeps the slot memory to zero, one slot a cycle,
// through all 2**INDEX_BITS slots (4096 at the default); s_tready stays low then.
// On accept, the request is registered and its slot is read from the slot
// memory into a register. In the decide state, once the output register is
// free, the block decides the hit or replacement, writes the slot and loads
// the result register, whose beat is valid from the edge that loads it. The
// block then returns to idle and takes no new request before the last one
// is decided.
// While the receiver stalls, one result waits in the output register and
// one further request can be accepted and read; its decision waits until
// the output register frees up.
module search_transposition_table
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key[63:0], depth[71:64], alpha[102:72], beta[133:103], value[164:134],
    // flag[166:165], move_src[175:167], move_to[184:176], zero[191:185]
    input  logic [stt_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cutoff[0], score[31:1], hint_valid[32], hint_from[41:33],
    // hint_to[50:42], written[51], zero[55:52]
    output logic [stt_pkg::M_TDATA_W-1:0] m_tdata
);
    import stt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    stt_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

[tb/search_transposition_table_tb.sv]
// testbench for the search transposition table: directed probes and stores, then random traffic
module search_transposition_table_tb;
    import stt_pkg::*;

    localparam int INDEX_BITS = 12;
    localparam int SLOTS      = 1 << INDEX_BITS;
    localparam int HOT_KEYS   = 24;
    localparam int PHASE_ITEMS = 210;

    typedef struct packed {
        logic                     func;
        logic [KEY_W-1:0]         key;
        logic [DEPTH_W-1:0]       depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] value;
        logic [BOUND_W-1:0]       flag;
        logic [SQ_W-1:0]          move_src;
        logic [SQ_W-1:0]          move_to;
    } tt_req_t;

    typedef struct packed {
        logic                      cutoff;
        logic signed [SCORE_W-1:0] score;
        logic                      hint_valid;
        logic [SQ_W-1:0]           hint_from;
        logic [SQ_W-1:0]           hint_to;
        logic                      written;
    } tt_res_t;

    typedef struct packed {
        tt_req_t req;
        logic    typed;
        tt_res_t res;
    } tt_row_t;

    localparam tt_res_t RES_MISS  = '{1'b0, 31'sd0, 1'b0, 9'h1FF, 9'h1FF, 1'b0};
    localparam tt_res_t RES_WROTE = '{1'b0, 31'sd0, 1'b0, 9'h1FF, 9'h1FF, 1'b1};
    localparam tt_res_t RES_EXACT_A = '{1'b1, 31'sh3FFF_FFFF, 1'b1, 9'h0FF, 9'h1FF, 1'b0};
    localparam tt_res_t RES_HINT_A  = '{1'b0, 31'sd0, 1'b1, 9'h0FF, 9'h1FF, 1'b0};

    localparam logic [KEY_W-1:0] KEY_A = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_B = 64'h8000_0000_0000_0FFF;
    localparam logic [KEY_W-1:0] KEY_C = 64'h0000_0000_0000_1000;
    localparam logic [KEY_W-1:0] KEY_D = 64'h0123_4567_89AB_C001;
    localparam logic [KEY_W-1:0] KEY_E = 64'h5555_5555_5555_5002;
    localparam logic [BOUND_W-1:0] BOUND_ODD = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    slot_t            slot_mirror [SLOTS];
    tt_res_t          pending_results [$];
    logic [KEY_W-1:0] hot_keys [HOT_KEYS];
    int               mismatches = 0;
    int               send_idle_pct = 19;
    int               recv_idle_pct = 79;
    int               stall_left = 0;
    int               stall_asks = 0;
    int               stall_seen = 0;

    search_transposition_table #(.INDEX_BITS(INDEX_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // applies one request to the mirrored table and returns what the block should answer
    function automatic tt_res_t table_access(tt_req_t r);
        slot_t                 s;
        tt_res_t               o;
        logic [INDEX_BITS-1:0] idx;
        idx = r.key[INDEX_BITS-1:0];
        s = slot_mirror[idx];
        o = RES_MISS;
        if (r.func == FUNC_STORE) begin
            if (s.key == '0 || s.depth <= r.depth) begin
                slot_mirror[idx] = '{to_sq: r.move_to, from_sq: r.move_src, bound: r.flag,
                                     score: r.value, depth: r.depth, key: r.key};
                o.written = 1'b1;
            end
        end
        else if (r.key != '0 && s.key == r.key) begin
            if (s.depth >= r.depth) begin
                if (s.bound == BOUND_EXACT) begin
                    o.cutoff = 1'b1;
                    o.hint_valid = 1'b1;
                end
                else if (s.bound == BOUND_LOWER && $signed(s.score) >= $signed(r.beta))
                    o.cutoff = 1'b1;
                else if (s.bound == BOUND_UPPER && $signed(s.score) <= $signed(r.alpha))
                    o.cutoff = 1'b1;
            end
            else
                o.hint_valid = 1'b1;
            if (o.cutoff)
                o.score = s.score;
            if (o.hint_valid) begin
                o.hint_from = s.from_sq;
                o.hint_to = s.to_sq;
            end
        end
        return o;
    endfunction

    function automatic tt_req_t mk_req(logic func, logic [KEY_W-1:0] key, int depth, int alpha,
                                       int beta, int value, logic [BOUND_W-1:0] flag,
                                       int move_src, int move_to);
        tt_req_t r;
        r.func = func;
        r.key = key;
        r.depth = depth[DEPTH_W-1:0];
        r.alpha = alpha[SCORE_W-1:0];
        r.beta = beta[SCORE_W-1:0];
        r.value = value[SCORE_W-1:0];
        r.flag = flag;
        r.move_src = move_src[SQ_W-1:0];
        r.move_to = move_to[SQ_W-1:0];
        return r;
    endfunction

    // mostly small scores so stored values and windows straddle each other
    function automatic logic [SCORE_W-1:0] rand_score();
        int v;
        if ($urandom_range(99) < 80)
            v = int'($urandom_range(0, 200)) - 100;
        else
            v = int'($urandom);
        return v[SCORE_W-1:0];
    endfunction

    function automatic tt_req_t random_request();
        tt_req_t r;
        int      pick;
        r.func = ($urandom_range(99) < 45) ? FUNC_STORE : FUNC_PROBE;
        pick = $urandom_range(99);
        if (pick < 5)
            r.key = '0;
        else if (pick < 15)
            r.key = {$urandom, $urandom};
        else
            r.key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        pick = $urandom_range(99);
        if (pick < 60)
            r.depth = DEPTH_W'($urandom_range(0, 7));
        else if (pick < 90)
            r.depth = DEPTH_W'($urandom_range(0, 255));
        else
            r.depth = $urandom_range(1) ? 8'd255 : 8'd0;
        r.alpha = rand_score();
        r.beta = rand_score();
        r.value = rand_score();
        r.flag = ($urandom_range(9) == 0) ? BOUND_ODD : BOUND_W'($urandom_range(0, 2));
        r.move_src = ($urandom_range(9) == 0) ? 9'h1FF : SQ_W'($urandom);
        r.move_to = ($urandom_range(9) == 0) ? 9'h1FF : SQ_W'($urandom);
        return r;
    endfunction

    task automatic send_request(tt_req_t r, logic typed, tt_res_t typed_res);
        tt_res_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.func;
        s_tdata <= {7'b0, r.move_to, r.move_src, r.flag, r.value, r.beta, r.alpha,
                    r.depth, r.key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = table_access(r);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // receiver, including the long hold-off that the stimulus asks for
    always @(posedge clk) begin
        if (stall_seen != stall_asks) begin
            m_tready <= 1'b0;
            stall_left <= 300;
            stall_seen <= stall_asks;
        end
        else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : result_check
        tt_res_t got;
        tt_res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.cutoff = m_tdata[0];
            got.score = m_tdata[31:1];
            got.hint_valid = m_tdata[32];
            got.hint_from = m_tdata[41:33];
            got.hint_to = m_tdata[50:42];
            got.written = m_tdata[51];
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing outstanding", '0, 64'(m_tdata));
            else begin
                want = pending_results.pop_front();
                if (got.cutoff !== want.cutoff)
                    report_mismatch("cutoff", 64'(want.cutoff), 64'(got.cutoff));
                if (got.score !== want.score)
                    report_mismatch("score", 64'(want.score), 64'(got.score));
                if (got.hint_valid !== want.hint_valid)
                    report_mismatch("hint_valid", 64'(want.hint_valid), 64'(got.hint_valid));
                if (got.hint_from !== want.hint_from)
                    report_mismatch("hint_from", 64'(want.hint_from), 64'(got.hint_from));
                if (got.hint_to !== want.hint_to)
                    report_mismatch("hint_to", 64'(want.hint_to), 64'(got.hint_to));
                if (got.written !== want.written)
                    report_mismatch("written", 64'(want.written), 64'(got.written));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        tt_row_t plan [$];
        int      hot_index [8];
        int      wait_cycles;
        for (int i = 0; i < SLOTS; i++)
            slot_mirror[i] = '0;
        for (int j = 0; j < 8; j++)
            hot_index[j] = int'($urandom_range(0, SLOTS - 1));
        // three keys per hot slot so replacement fights happen
        for (int i = 0; i < HOT_KEYS; i++) begin
            hot_keys[i] = {$urandom, $urandom};
            hot_keys[i][INDEX_BITS-1:0] = INDEX_BITS'(hot_index[i % 8]);
        end

        plan.push_back('{mk_req(FUNC_PROBE, '0, 0, 0, 0, 0, BOUND_EXACT, -1, -1),
                         1'b1, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, 64'h1, 0, 0, 0, 0, BOUND_EXACT, -1, -1),
                         1'b1, RES_MISS});
        // key zero stored into slot zero stays empty
        plan.push_back('{mk_req(FUNC_STORE, '0, 255, 0, 0, 0, BOUND_EXACT, 5, 6),
                         1'b1, RES_WROTE});
        plan.push_back('{mk_req(FUNC_PROBE, '0, 0, 0, 0, 0, BOUND_EXACT, -1, -1),
                         1'b1, RES_MISS});
        plan.push_back('{mk_req(FUNC_STORE, KEY_A, 10, 0, 0, 1073741823, BOUND_EXACT, 255, -1),
                         1'b1, RES_WROTE});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_A, 10, 0, 0, 0, BOUND_EXACT, 0, 0),
                         1'b1, RES_EXACT_A});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_A, 11, 0, 0, 0, BOUND_EXACT, 0, 0),
                         1'b1, RES_HINT_A});
        plan.push_back('{mk_req(FUNC_STORE, KEY_A, 9, 0, 0, 5, BOUND_EXACT, 1, 1),
                         1'b1, RES_MISS});
        // same slot, equal depth replaces
        plan.push_back('{mk_req(FUNC_STORE, KEY_B, 10, 0, 0, -1000000000, BOUND_LOWER, 3, 4),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_A, 0, 0, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_B, 10, 0, -1000000000, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_B, 10, 0, -999999999, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_STORE, KEY_C, 255, 0, 0, -1073741824, BOUND_UPPER, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_C, 255, -1073741824, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_C, 255, 1073741823, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_STORE, KEY_D, 0, 0, 0, 100, BOUND_UPPER, 12, 28),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_D, 0, 99, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_D, 0, 100, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_D, 1, 100, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        // bound kind three: deep hit gives nothing, shallow hit still hints
        plan.push_back('{mk_req(FUNC_STORE, KEY_E, 5, 0, 0, 7, BOUND_ODD, 1, 2),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_E, 5, 1000, -1000, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_E, 6, 0, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_STORE, KEY_E, 4, 0, 0, 9, BOUND_EXACT, 7, 7),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_STORE, KEY_E, 5, 0, 0, -7, BOUND_EXACT, 8, 9),
                         1'b0, RES_MISS});
        plan.push_back('{mk_req(FUNC_PROBE, KEY_E, 0, 0, 0, 0, BOUND_EXACT, 0, 0),
                         1'b0, RES_MISS});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].res);
        drain();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 19 : (p == 1) ? 79 : 0;
            recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 19 : 0;
            // long receiver hold-off while requests keep coming
            if (p == 2)
                stall_asks++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(), 1'b0, RES_MISS);
            drain();
        end

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[search_transposition_table.f]
rtl/stt_pkg.sv
rtl/stt_ctrl.sv
rtl/stt_datapath.sv
rtl/search_transposition_table.sv
tb/search_transposition_table_tb.sv
